[sv/eight_bit_cpu_base_opcodes_macros.svh]
// Assertion macros used by the checker file ebc_checker.
`ifndef EIGHT_BIT_CPU_BASE_OPCODES_MACROS_SVH
`define EIGHT_BIT_CPU_BASE_OPCODES_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ebc_pkg.sv]
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants for the 8-bit CPU base opcode core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebc_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] opcode;
        logic [7:0] operand_low;
        logic [7:0] operand_high;
        logic [7:0] read_data;
    } in_word_t;

    typedef struct packed {
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        bus_write;
        logic        bus_read;
        logic [2:0]  cycles;
        logic [15:0] next_pc;
        logic [7:0]  accumulator;
        logic [3:0]  flag_bits;
        logic [2:0]  event_res;
        logic        last;
    } out_word_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_LOAD = 2'd1,
        PEND_INC  = 2'd2,
        PEND_DEC  = 2'd3
    } pend_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_HALT   = 3'd1,
        EV_STOP   = 3'd2,
        EV_UNIMPL = 3'd3,
        EV_ORDER  = 3'd4
    } event_t;

    localparam logic [2:0] R_B = 3'd0;
    localparam logic [2:0] R_C = 3'd1;
    localparam logic [2:0] R_D = 3'd2;
    localparam logic [2:0] R_E = 3'd3;
    localparam logic [2:0] R_H = 3'd4;
    localparam logic [2:0] R_L = 3'd5;
    localparam logic [2:0] R_A = 3'd6;

    localparam int FZ = 3;
    localparam int FN = 2;
    localparam int FH = 1;
    localparam int FC = 0;

    localparam logic [7:0]  OP_LD_A16_SP = 8'h08;
    localparam logic [7:0]  OP_STOP      = 8'h10;
    localparam logic [7:0]  OP_JR_NZ     = 8'h20;
    localparam logic [7:0]  OP_JR_Z      = 8'h28;
    localparam logic [7:0]  OP_JR_NC     = 8'h30;
    localparam logic [7:0]  OP_JR_C      = 8'h38;
    localparam logic [7:0]  OP_HALT      = 8'h76;
    localparam logic [7:0]  OP_RLCA      = 8'h07;
    localparam logic [7:0]  OP_RRCA      = 8'h0F;
    localparam logic [7:0]  OP_RLA       = 8'h17;
    localparam logic [7:0]  OP_RRA       = 8'h1F;
    localparam logic [7:0]  OP_DAA       = 8'h27;
    localparam logic [7:0]  OP_CPL       = 8'h2F;
    localparam logic [7:0]  OP_SCF       = 8'h37;

    localparam logic [7:0]  RST_A  = 8'h01;
    localparam logic [7:0]  RST_B  = 8'h00;
    localparam logic [7:0]  RST_C  = 8'h13;
    localparam logic [7:0]  RST_D  = 8'h00;
    localparam logic [7:0]  RST_E  = 8'hD8;
    localparam logic [7:0]  RST_H  = 8'h01;
    localparam logic [7:0]  RST_L  = 8'h4D;
    localparam logic [3:0]  RST_F  = 4'hB;
    localparam logic [15:0] RST_SP = 16'hFFFE;
    localparam logic [15:0] RST_PC = 16'h0100;

endpackage

[sv/eight_bit_cpu_base_opcodes.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_base_opcodes
// Executes base opcodes 0x00-0x7F, one instruction word per cycle if not held.
// ----------------------------------------------------------------------------
// Each accepted input word is executed by one pass of combinational logic
// from the register file into an output register; a new word is taken in
// every cycle while the output register is free or being drained and no
// second store is pending. Memory reads return a bus request and wait for
// a read-data word (mode 1). LD (a16),SP yields two result words and holds
// off the input while the second write is emitted.
`timescale 1ns / 1ps

module eight_bit_cpu_base_opcodes (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ebc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ebc_pkg::out_word_t out_data
);
    import ebc_pkg::*;

    logic [7:0]  rg_reg [7];
    logic [7:0]  rg_next [7];
    logic [3:0]  f_reg, f_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    pend_t       pk_reg, pk_next;
    logic [2:0]  pt_reg, pt_next;
    logic        ov_reg;
    out_word_t   od_reg, r0;
    logic        sec_reg, sec_next;
    logic [15:0] sec_addr_reg, sec_addr_next;
    logic [7:0]  sec_data_reg, sec_data_next;
    logic        two;
    logic        adv, fire;

    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv && !sec_reg;
    assign fire     = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic [2:0] ridx(input logic [2:0] c);
        return (c >= 3'd6) ? R_A : c;
    endfunction

    always_comb
    begin
        logic [7:0]  op, lo, hi, a, v, s;
        logic [2:0]  lo3, dst, src;
        logic [1:0]  p, q;
        logic [15:0] hl, pv, addr, n16;
        logic [16:0] sum;
        logic [12:0] hsum;
        logic [15:0] len;
        logic [7:0]  off;
        logic        c, nc, take;
        op = in_data.opcode;
        lo = in_data.operand_low;
        hi = in_data.operand_high;
        lo3 = op[2:0];
        dst = op[5:3];
        src = op[2:0];
        p = op[5:4];
        a = rg_reg[R_A];
        hl = {rg_reg[R_H], rg_reg[R_L]};
        n16 = {hi, lo};
        for (int i = 0; i < 7; i++) rg_next[i] = rg_reg[i];
        f_next = f_reg;
        sp_next = sp_reg;
        pc_next = pc_reg;
        pk_next = pk_reg;
        pt_next = pt_reg;
        sec_next = 1'b0;
        sec_addr_next = sec_addr_reg;
        sec_data_next = sec_data_reg;
        two = 1'b0;
        len = 16'd1;
        r0 = '0;
        r0.cycles = 3'd1;
        r0.last = 1'b1;
        v = '0; s = '0; sum = '0; hsum = '0; off = '0; c = 1'b0; nc = 1'b0;
        take = 1'b1; addr = '0; q = '0;
        case (p)
            2'd0: pv = {rg_reg[R_B], rg_reg[R_C]};
            2'd1: pv = {rg_reg[R_D], rg_reg[R_E]};
            2'd2: pv = hl;
            default: pv = sp_reg;
        endcase

        if (in_data.mode) begin
            r0.cycles = 3'd0;
            len = 16'd0;
            case (pk_reg)
                PEND_NONE: r0.event_res = EV_ORDER;
                PEND_LOAD:
                begin
                    rg_next[ridx(pt_reg)] = in_data.read_data;
                    pk_next = PEND_NONE;
                end
                default:
                begin
                    s = in_data.read_data;
                    if (pk_reg == PEND_INC) begin
                        v = s + 8'd1;
                        f_next[FN] = 1'b0;
                        f_next[FH] = (s[3:0] == 4'hF);
                    end else begin
                        v = s - 8'd1;
                        f_next[FN] = 1'b1;
                        f_next[FH] = (s[3:0] == 4'h0);
                    end
                    f_next[FZ] = (v == 8'd0);
                    pk_next = PEND_NONE;
                    r0.bus_address = hl;
                    r0.write_data = v;
                    r0.bus_write = 1'b1;
                end
            endcase
        end else if (pk_reg != PEND_NONE || op[7]) begin
            r0.cycles = 3'd0;
            len = 16'd0;
            r0.event_res = (pk_reg != PEND_NONE) ? EV_ORDER : EV_UNIMPL;
        end else if (op[6]) begin
            if (op == OP_HALT) r0.event_res = EV_HALT;
            else if (dst == 3'd6) begin
                r0.bus_address = hl; r0.write_data = rg_reg[ridx(src)];
                r0.bus_write = 1'b1; r0.cycles = 3'd2;
            end else if (src == 3'd6) begin
                r0.bus_address = hl; r0.bus_read = 1'b1; r0.cycles = 3'd2;
                pk_next = PEND_LOAD; pt_next = ridx(dst);
            end else rg_next[ridx(dst)] = rg_reg[ridx(src)];
        end else begin
            case (lo3)
                3'd0:
                begin
                    if (op == OP_LD_A16_SP) begin
                        two = 1'b1;
                        len = 16'd3;
                        r0.bus_address = n16; r0.write_data = sp_reg[7:0];
                        r0.bus_write = 1'b1; r0.cycles = 3'd5; r0.last = 1'b0;
                        sec_next = 1'b1;
                        sec_addr_next = n16 + 16'd1;
                        sec_data_next = sp_reg[15:8];
                    end else if (op == OP_STOP) begin
                        r0.event_res = EV_STOP; len = 16'd2;
                    end else if (op >= 8'h18) begin
                        len = 16'd2; r0.cycles = 3'd2;
                        case (op)
                            OP_JR_NZ: take = !f_reg[FZ];
                            OP_JR_Z:  take = f_reg[FZ];
                            OP_JR_NC: take = !f_reg[FC];
                            OP_JR_C:  take = f_reg[FC];
                            default:  take = 1'b1;
                        endcase
                        if (take) begin
                            r0.cycles = 3'd3;
                            len = 16'd2 + {{8{lo[7]}}, lo};
                        end
                    end
                end
                3'd1:
                begin
                    if (op[3]) begin
                        sum = {1'b0, hl} + {1'b0, pv};
                        hsum = {1'b0, hl[11:0]} + {1'b0, pv[11:0]};
                        f_next[FN] = 1'b0;
                        f_next[FH] = hsum[12];
                        f_next[FC] = sum[16];
                        {rg_next[R_H], rg_next[R_L]} = sum[15:0];
                        r0.cycles = 3'd2;
                    end else begin
                        case (p)
                            2'd0: {rg_next[R_B], rg_next[R_C]} = n16;
                            2'd1: {rg_next[R_D], rg_next[R_E]} = n16;
                            2'd2: {rg_next[R_H], rg_next[R_L]} = n16;
                            default: sp_next = n16;
                        endcase
                        len = 16'd3; r0.cycles = 3'd3;
                    end
                end
                3'd2:
                begin
                    q = p[1] ? 2'd2 : p;
                    case (q)
                        2'd0: addr = {rg_reg[R_B], rg_reg[R_C]};
                        2'd1: addr = {rg_reg[R_D], rg_reg[R_E]};
                        default: addr = hl;
                    endcase
                    r0.bus_address = addr; r0.cycles = 3'd2;
                    if (op[3]) begin
                        r0.bus_read = 1'b1; pk_next = PEND_LOAD; pt_next = R_A;
                    end else begin
                        r0.bus_write = 1'b1; r0.write_data = a;
                    end
                    if (p == 2'd2) {rg_next[R_H], rg_next[R_L]} = addr + 16'd1;
                    if (p == 2'd3) {rg_next[R_H], rg_next[R_L]} = addr - 16'd1;
                end
                3'd3:
                begin
                    addr = op[3] ? pv - 16'd1 : pv + 16'd1;
                    case (p)
                        2'd0: {rg_next[R_B], rg_next[R_C]} = addr;
                        2'd1: {rg_next[R_D], rg_next[R_E]} = addr;
                        2'd2: {rg_next[R_H], rg_next[R_L]} = addr;
                        default: sp_next = addr;
                    endcase
                    r0.cycles = 3'd2;
                end
                3'd4, 3'd5:
                begin
                    if (dst == 3'd6) begin
                        r0.bus_address = hl; r0.bus_read = 1'b1; r0.cycles = 3'd3;
                        pk_next = lo3[0] ? PEND_DEC : PEND_INC;
                    end else begin
                        s = rg_reg[ridx(dst)];
                        if (!lo3[0]) begin
                            v = s + 8'd1;
                            f_next[FN] = 1'b0;
                            f_next[FH] = (s[3:0] == 4'hF);
                        end else begin
                            v = s - 8'd1;
                            f_next[FN] = 1'b1;
                            f_next[FH] = (s[3:0] == 4'h0);
                        end
                        f_next[FZ] = (v == 8'd0);
                        rg_next[ridx(dst)] = v;
                    end
                end
                3'd6:
                begin
                    len = 16'd2; r0.cycles = 3'd2;
                    if (dst == 3'd6) begin
                        r0.bus_address = hl; r0.write_data = lo;
                        r0.bus_write = 1'b1; r0.cycles = 3'd3;
                    end else rg_next[ridx(dst)] = lo;
                end
                default:
                begin
                    c = f_reg[FC];
                    case (op)
                        OP_RLCA: begin c = a[7]; a = {a[6:0], a[7]}; end
                        OP_RRCA: begin c = a[0]; a = {a[0], a[7:1]}; end
                        OP_RLA:  begin nc = a[7]; a = {a[6:0], c}; c = nc; end
                        OP_RRA:  begin nc = a[0]; a = {c, a[7:1]}; c = nc; end
                        default: ;
                    endcase
                    if (op <= OP_RRA) f_next = {3'b000, c};
                    else if (op == OP_DAA) begin
                        if (!f_reg[FN]) begin
                            if (f_reg[FH] || a[3:0] > 4'h9) off[2:1] = 2'b11;
                            if (f_reg[FC] || a > 8'h99) begin
                                off[6:5] = 2'b11; f_next[FC] = 1'b1;
                            end
                            a = a + off;
                        end else begin
                            if (f_reg[FH]) off[2:1] = 2'b11;
                            if (f_reg[FC]) off[6:5] = 2'b11;
                            a = a - off;
                        end
                        f_next[FZ] = (a == 8'd0);
                        f_next[FH] = 1'b0;
                    end else if (op == OP_CPL) begin
                        a = ~a; f_next[FN] = 1'b1; f_next[FH] = 1'b1;
                    end else begin
                        f_next[FN] = 1'b0; f_next[FH] = 1'b0;
                        f_next[FC] = (op == OP_SCF) ? 1'b1 : !c;
                    end
                    rg_next[R_A] = a;
                end
            endcase
        end
        pc_next = pc_reg + len;
        r0.next_pc = pc_next;
        r0.accumulator = rg_next[R_A];
        r0.flag_bits = f_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rg_reg[R_B] <= RST_B; rg_reg[R_C] <= RST_C;
            rg_reg[R_D] <= RST_D; rg_reg[R_E] <= RST_E;
            rg_reg[R_H] <= RST_H; rg_reg[R_L] <= RST_L;
            rg_reg[R_A] <= RST_A;
            f_reg <= RST_F;
            sp_reg <= RST_SP;
            pc_reg <= RST_PC;
            pk_reg <= PEND_NONE;
            pt_reg <= R_B;
            ov_reg <= 1'b0;
            sec_reg <= 1'b0;
        end else if (adv) begin
            if (sec_reg) begin
                ov_reg <= 1'b1;
                sec_reg <= 1'b0;
            end else begin
                ov_reg <= fire;
                if (fire) begin
                    for (int i = 0; i < 7; i++) rg_reg[i] <= rg_next[i];
                    f_reg <= f_next;
                    sp_reg <= sp_next;
                    pc_reg <= pc_next;
                    pk_reg <= pk_next;
                    pt_reg <= pt_next;
                    sec_reg <= sec_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            if (sec_reg) begin
                od_reg.bus_address <= sec_addr_reg;
                od_reg.write_data <= sec_data_reg;
                od_reg.cycles <= 3'd0;
                od_reg.last <= 1'b1;
            end else if (fire) begin
                od_reg <= r0;
                if (two) begin
                    sec_addr_reg <= sec_addr_next;
                    sec_data_reg <= sec_data_next;
                end
            end
        end
    end

endmodule

[sv/ebc_checker.sv]
// ----------------------------------------------------------------------------
// ebc_checker
// Port-level checks for the CPU core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eight_bit_cpu_base_opcodes_macros.svh"

module ebc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input ebc_pkg::in_word_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input ebc_pkg::out_word_t out_data
);
    import ebc_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
    `ASSERT_IMPL(a_rw_excl, clk, rst_n, out_valid, !(out_data.bus_read && out_data.bus_write), "read and write together")
    `ASSERT_IMPL(a_first_last, clk, rst_n, out_valid && !out_data.last, out_data.bus_write && out_data.cycles == 3'd5, "non-final result not a wide store")
    `ASSERT_NEXT(a_pair, clk, rst_n, out_valid && out_ready && !out_data.last, out_valid && out_data.last && out_data.bus_write, "second store missing")

endmodule

bind eight_bit_cpu_base_opcodes ebc_checker u_ebc_checker (.*);
